// File: design/pixel_replication_upscaler_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef PIXEL_REPLICATION_UPSCALER_UNIT_ASSERT_SVH
`define PIXEL_REPLICATION_UPSCALER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define PRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pru assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define PRU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pru assertion failed");

// Next-cycle implication that also holds across reset.
`define PRU_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pru assertion failed");

`endif

// File: design/pru_pkg.sv
package pru_pkg;

  localparam int MAX_SCALE = 16;
  localparam int MAX_WIDTH = 2048;

  localparam int PIX_W  = 24;
  localparam int SCL_W  = 5;
  localparam int WID_W  = 12;
  localparam int ROWS_W = 4;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CPY_W  = $clog2(MAX_SCALE + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_PAD    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  localparam logic REG_SCALE     = 1'b0;
  localparam logic REG_ROW_WIDTH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PIX_W-1:0] pixel_out;
    logic [1:0]       pad_count;
    logic             row_end;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [SCL_W-1:0] scale;
    logic [WID_W-1:0] row_width;
  } cfg_t;

  // Work item handed from the front end to the emitter.
  typedef struct packed {
    logic             reject;
    logic [PIX_W-1:0] pixel;
    logic             end_row;
    logic [CPY_W-1:0] copies;
    logic [1:0]       pad;
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_PUSH,
    SRC_REPLAY,
    SRC_REJECT
  } src_t;

  function automatic logic [CPY_W-1:0] eff_scale(input logic [SCL_W-1:0] s);
    if (s == '0) begin
      return CPY_W'(1);
    end else if (int'(s) > MAX_SCALE) begin
      return CPY_W'(MAX_SCALE);
    end
    return CPY_W'(s);
  endfunction

  function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
    if (w == '0) begin
      return WID_W'(1);
    end else if (int'(w) > MAX_WIDTH) begin
      return WID_W'(MAX_WIDTH);
    end
    return w;
  endfunction

  // Zero bytes that pad w*s*3 bytes to a multiple of four: equals (w*s) mod 4.
  function automatic logic [1:0] row_pad(input logic [WID_W-1:0] w,
                                         input logic [CPY_W-1:0] s);
    logic [3:0] prod;
    prod = {2'b00, w[1:0]} * {2'b00, s[1:0]};
    return prod[1:0];
  endfunction

endpackage

// File: design/pru_ram.sv
module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/pru_queue.sv
module pru_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  pru_pkg::cmd_t             wdata,
  input  logic                      pop,
  output pru_pkg::cmd_t             rdata,
  output logic                      not_empty,
  output logic [pru_pkg::QCNT_W-1:0] level
);
  import pru_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // push is held off upstream when full; pop only when not empty
  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata     = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign level     = count_r;

endmodule

// File: design/pru_front.sv
module pru_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pru_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pru_pkg::in_item_t          in_data,
  input  logic [pru_pkg::QCNT_W-1:0] q_level,
  output logic                       ram_we,
  output logic [pru_pkg::COL_W-1:0]  ram_waddr,
  output logic [pru_pkg::PIX_W-1:0]  ram_wdata,
  output logic                       ram_re,
  output logic [pru_pkg::COL_W-1:0]  ram_raddr,
  input  logic [pru_pkg::PIX_W-1:0]  ram_rdata,
  output logic                       q_push,
  output pru_pkg::cmd_t              q_wdata
);
  import pru_pkg::*;

  logic [COL_W-1:0]  wcol_r, wcol_nxt;
  logic [COL_W-1:0]  rcol_r, rcol_nxt;
  logic [ROWS_W-1:0] rows_left_r, rows_left_nxt;
  logic              stg_valid_r, stg_valid_nxt;
  src_t              stg_src_r, stg_src_nxt;
  cmd_t              stg_cmd_r, stg_cmd_nxt;

  logic              accept;
  logic [WID_W-1:0]  w_eff;
  logic [CPY_W-1:0]  s_eff;
  logic [WID_W:0]    wcol_inc;
  logic [WID_W:0]    rcol_inc;
  logic              wend;
  logic              rend;

  // room is reserved for the item held in the stage register
  assign in_stall = ((QCNT_W + 1)'(q_level) + (QCNT_W + 1)'(stg_valid_r))
                    >= (QCNT_W + 1)'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  assign w_eff    = eff_width(cfg.row_width);
  assign s_eff    = eff_scale(cfg.scale);
  assign wcol_inc = (WID_W + 1)'(wcol_r) + 1'b1;
  assign rcol_inc = (WID_W + 1)'(rcol_r) + 1'b1;
  assign wend     = wcol_inc >= {1'b0, w_eff};
  assign rend     = rcol_inc >= {1'b0, w_eff};

  always_comb begin
    wcol_nxt      = wcol_r;
    rcol_nxt      = rcol_r;
    rows_left_nxt = rows_left_r;
    stg_valid_nxt = 1'b0;
    stg_src_nxt   = stg_src_r;
    stg_cmd_nxt   = stg_cmd_r;
    ram_we        = 1'b0;
    ram_waddr     = wcol_r;
    ram_wdata     = in_data.pixel_in;
    ram_re        = 1'b0;
    ram_raddr     = rcol_r;

    if (accept) begin
      stg_cmd_nxt.copies = s_eff;
      stg_cmd_nxt.pad    = row_pad(w_eff, s_eff);
      stg_cmd_nxt.pixel  = in_data.pixel_in;
      stg_cmd_nxt.reject = 1'b0;
      if (in_data.op == OP_PUSH) begin
        stg_valid_nxt = 1'b1;
        if (rows_left_r != '0) begin
          // replay still pending: push refused
          stg_src_nxt         = SRC_REJECT;
          stg_cmd_nxt.reject  = 1'b1;
          stg_cmd_nxt.end_row = 1'b0;
        end else begin
          stg_src_nxt         = SRC_PUSH;
          stg_cmd_nxt.end_row = wend;
          ram_we              = 1'b1;
          if (wend) begin
            wcol_nxt      = '0;
            rcol_nxt      = '0;
            rows_left_nxt = ROWS_W'(s_eff - 1'b1);
          end else begin
            wcol_nxt = COL_W'(wcol_inc);
          end
        end
      end else if (rows_left_r != '0) begin
        // replay: pixel comes from the line store next cycle
        stg_valid_nxt       = 1'b1;
        stg_src_nxt         = SRC_REPLAY;
        stg_cmd_nxt.end_row = rend;
        ram_re              = 1'b1;
        if (rend) begin
          rcol_nxt      = '0;
          rows_left_nxt = ROWS_W'(rows_left_r - 1'b1);
        end else begin
          rcol_nxt = COL_W'(rcol_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r      <= '0;
      rcol_r      <= '0;
      rows_left_r <= '0;
      stg_valid_r <= 1'b0;
      stg_src_r   <= SRC_PUSH;
    end else begin
      wcol_r      <= wcol_nxt;
      rcol_r      <= rcol_nxt;
      rows_left_r <= rows_left_nxt;
      stg_valid_r <= stg_valid_nxt;
      stg_src_r   <= stg_src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_cmd_r <= stg_cmd_nxt;
  end

  always_comb begin
    q_push  = stg_valid_r;
    q_wdata = stg_cmd_r;
    case (stg_src_r)
      SRC_REPLAY: q_wdata.pixel = ram_rdata;
      SRC_REJECT: q_wdata.pixel = '0;
      default:    q_wdata.pixel = stg_cmd_r.pixel;
    endcase
  end

endmodule

// File: design/pru_back.sv
module pru_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pru_pkg::cmd_t      q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pru_pkg::out_item_t out_data
);
  import pru_pkg::*;

  logic [CPY_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             load;
  logic             final_copy;

  assign load       = q_valid && (!out_valid_r || !out_stall);
  assign final_copy = (cnt_r == CPY_W'(q_rdata.copies - 1'b1));

  always_comb begin
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (q_rdata.reject) begin
        out_data_nxt.kind = KIND_REJECT;
        out_data_nxt.last = 1'b1;
        q_pop             = 1'b1;
      end else if (cnt_r < q_rdata.copies) begin
        out_data_nxt.kind      = KIND_PIXEL;
        out_data_nxt.pixel_out = q_rdata.pixel;
        out_data_nxt.last      = final_copy && !q_rdata.end_row;
        if (final_copy && !q_rdata.end_row) begin
          q_pop   = 1'b1;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = CPY_W'(cnt_r + 1'b1);
        end
      end else begin
        // all copies out: close the row with padding
        out_data_nxt.kind      = KIND_PAD;
        out_data_nxt.pad_count = q_rdata.pad;
        out_data_nxt.row_end   = 1'b1;
        out_data_nxt.last      = 1'b1;
        q_pop                  = 1'b1;
        cnt_nxt                = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/pixel_replication_upscaler_unit.sv
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+---------------------------------------
// in      | in  | in_valid / in_stall  | in_data  (op, pixel_in)
// out     | out | out_valid / out_stall| out_data (kind, pixel_out, pad_count,
//         |     |                      |           row_end, last)
// cfg     | in  | APB psel/penable     | scale @ 0x0, row_width @ 0x4
//
// One item is taken per cycle while the command queue has room. The result
// channel sets the sustained rate: a pixel item yields scale results, plus
// one padding result at a row end; a rejected push yields one result. The
// first result passes through the stage register, the queue and the output
// register. Reset is synchronous, active low; the line store
// is not cleared. out_stall only holds the output register; the queue keeps
// absorbing items until it is full, then in_stall rises.
module pixel_replication_upscaler_unit (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  pru_pkg::in_item_t  in_data,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output pru_pkg::out_item_t out_data,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pru_pkg::*;

  // configuration registers
  logic [SCL_W-1:0] scale_r, scale_nxt;
  logic [WID_W-1:0] row_width_r, row_width_nxt;
  logic             cfg_wr;
  cfg_t             cfg;

  // front end <-> line store
  logic             ram_we;
  logic [COL_W-1:0] ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic             ram_re;
  logic [COL_W-1:0] ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  // front end <-> queue <-> emitter
  logic              q_push;
  cmd_t              q_wdata;
  logic              q_pop;
  cmd_t              q_rdata;
  logic              q_valid;
  logic [QCNT_W-1:0] q_level;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register index is paddr[2]; byte lanes below it are ignored
  always_comb begin
    scale_nxt     = scale_r;
    row_width_nxt = row_width_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_SCALE:     scale_nxt     = pwdata[SCL_W-1:0];
        REG_ROW_WIDTH: row_width_nxt = pwdata[WID_W-1:0];
        default:       scale_nxt     = scale_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCL_W'(1);
      row_width_r <= WID_W'(1);
    end else begin
      scale_r     <= scale_nxt;
      row_width_r <= row_width_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE:     prdata = {{(32 - SCL_W){1'b0}}, scale_r};
      REG_ROW_WIDTH: prdata = {{(32 - WID_W){1'b0}}, row_width_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.scale     = scale_r;
  assign cfg.row_width = row_width_r;

  // front end: classify items, track columns and pending replay rows
  pru_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_level   (q_level),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // one input row of pixels
  pru_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // decouples classification from the multi-cycle emit
  pru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid),
    .level     (q_level)
  );

  // emitter: scale copies, then padding at a row end
  pru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: design/pru_checker.sv
`include "pixel_replication_upscaler_unit_assert.svh"

module pru_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input pru_pkg::out_item_t out_data
);
  import pru_pkg::*;

  `PRU_ASSERT_NXT_ALWAYS(a_rst_quiet, clk, !rst_n, !out_valid)
  `PRU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `PRU_ASSERT_NOW(a_reject_alone, clk, rst_n, out_valid && out_data.kind == KIND_REJECT, out_data.last && out_data.pixel_out == '0)
  `PRU_ASSERT_NOW(a_row_end_pad, clk, rst_n, out_valid, out_data.row_end == (out_data.kind == KIND_PAD))
  `PRU_ASSERT_NOW(a_pad_last, clk, rst_n, out_valid && out_data.kind == KIND_PAD, out_data.last && out_data.pixel_out == '0)

endmodule

bind pixel_replication_upscaler_unit pru_checker u_pru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: verif/tb_pixel_replication_upscaler_unit.sv
module tb_pixel_replication_upscaler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pru_pkg::*;

  // Random part stops once this many items that the block acts on are queued
  // (ignored replays do not count).
  localparam int ITEM_TARGET = 430;
  // Long receiver hold-off used once to fill the block and back up its input.
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed after the last expected result.
  localparam int SETTLE = 8;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_replication_upscaler_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #4ms;
    $display("pixel_replication_upscaler_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: line store, column pointers, pending replay rows and
  // the two registers as last written.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] row_mem [MAX_WIDTH];
  int unsigned      wr_col = 0;
  int unsigned      rp_col = 0;
  int unsigned      rows_pending = 0;
  logic [SCL_W-1:0] scale_reg = 5'd1;
  logic [WID_W-1:0] width_reg = 12'd1;

  out_item_t upscaled_q[$];   // results still owed by the block, oldest first
  in_item_t  pixel_items[$];  // items waiting for the driver

  int n_sent = 0;    // items handed to the driver
  int n_real = 0;    // of those, items the block does not ignore
  int n_in = 0;      // items taken by the block
  int n_out = 0;     // results taken from the block
  int mismatches = 0;

  bit calm = 1'b0;   // both sides skip their random gaps while set
  int hold_reqs = 0; // bumped by the sequencer to request a long hold-off

  // Register values outside the legal range saturate.
  function automatic int unsigned eff_scale_of(logic [SCL_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SCALE) return MAX_SCALE;
    return v;
  endfunction

  function automatic int unsigned eff_width_of(logic [WID_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned next_gap();
    if (calm) return 0;
    return $urandom_range(0, 15);
  endfunction

  // One pixel goes out scale times; a finished row adds a padding result
  // that brings the output row (width * scale * 3 bytes) to a 4-byte multiple.
  task automatic replicate(logic [PIX_W-1:0] pix, bit row_done);
    int unsigned s;
    int unsigned pad;
    out_item_t   r;
    s = eff_scale_of(scale_reg);
    for (int i = 0; i < s; i++) begin
      r = '0;
      r.kind = KIND_PIXEL;
      r.pixel_out = pix;
      r.last = !row_done && (i == s - 1);
      upscaled_q.push_back(r);
    end
    if (row_done) begin
      pad = (4 - (eff_width_of(width_reg) * s * 3) % 4) % 4;
      r = '0;
      r.kind = KIND_PAD;
      r.pad_count = pad[1:0];
      r.row_end = 1'b1;
      r.last = 1'b1;
      upscaled_q.push_back(r);
    end
  endtask

  task automatic upscale_item(in_item_t it);
    int unsigned      w;
    bit               row_done;
    out_item_t        r;
    logic [PIX_W-1:0] v;
    w = eff_width_of(width_reg);
    if (it.op == OP_PUSH) begin
      // New pixels are refused while stored rows still wait for replay.
      if (rows_pending != 0) begin
        r = '0;
        r.kind = KIND_REJECT;
        r.last = 1'b1;
        upscaled_q.push_back(r);
        return;
      end
      row_mem[wr_col] = it.pixel_in;
      // A column at or past the last one ends the row, so a width that
      // shrank mid-row closes it on the next push.
      row_done = (wr_col + 1 >= w);
      if (row_done) begin
        wr_col = 0;
        rp_col = 0;
        rows_pending = (eff_scale_of(scale_reg) - 1) & 4'hF;
      end else begin
        wr_col = (wr_col + 1) % MAX_WIDTH;
      end
      replicate(it.pixel_in, row_done);
    end else if (rows_pending != 0) begin
      // Replay with nothing pending is dropped without a result.
      v = row_mem[rp_col];
      row_done = (rp_col + 1 >= w);
      if (row_done) begin
        rp_col = 0;
        rows_pending = rows_pending - 1;
      end else begin
        rp_col = (rp_col + 1) % MAX_WIDTH;
      end
      replicate(v, row_done);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (upscaled_q.size() == 0) begin
      $error("unexpected result: kind %0d pixel %06h pad %0d row_end %0b last %0b",
             got.kind, got.pixel_out, got.pad_count, got.row_end, got.last);
      mismatches++;
      return;
    end
    want = upscaled_q.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.pixel_out !== want.pixel_out) begin
      $error("pixel_out: expected %06h, got %06h", want.pixel_out, got.pixel_out);
      mismatches++;
    end
    if (got.pad_count !== want.pad_count) begin
      $error("pad_count: expected %0d, got %0d", want.pad_count, got.pad_count);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge, before the block's
  // own registers move.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_in++;
        upscale_item(in_data);
      end
      if (out_valid && !out_stall) begin
        n_out++;
        check_result(out_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers items from pixel_items at the falling edge and holds each
  // one until the monitor has seen it taken, then waits a random gap.
  // ---------------------------------------------------------------------------
  int  tx_seen = 0;
  int  tx_gap = 0;
  bit  offering = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (offering && tx_seen != n_in) begin
        tx_seen = n_in;
        offering = 1'b0;
        tx_gap = next_gap();
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pixel_items.size() != 0) begin
          in_data <= pixel_items.pop_front();
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after every result taken, plus a long hold-off on
  // request, counted here.
  // ---------------------------------------------------------------------------
  int rx_seen = 0;
  int rx_gap = 0;
  int hold_taken = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_taken != hold_reqs) begin
        hold_taken = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (rx_seen != n_out) begin
        rx_seen = n_out;
        rx_gap = next_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where pready is seen high.
  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SCALE) begin
      scale_reg = val[SCL_W-1:0];
    end else begin
      width_reg = val[WID_W-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic queue_item(logic op, logic [PIX_W-1:0] pix, bit acted_on);
    in_item_t it;
    it.op = op;
    it.pixel_in = pix;
    pixel_items.push_back(it);
    n_sent++;
    if (acted_on) n_real++;
  endtask

  // Block is idle once every item is taken and every result is back; an
  // ignored replay may still be in flight, hence the settle time.
  task automatic drain();
    while (n_in != n_sent || upscaled_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // A well-formed row: w pushes, then (scale-1)*w replays. Noise is a push
  // slipped into the replay stretch (rejected) or a replay after it (dropped).
  task automatic send_row(bit noisy);
    int unsigned w;
    int unsigned reps;
    w = eff_width_of(width_reg);
    reps = eff_scale_of(scale_reg) - 1;
    for (int c = 0; c < w; c++) queue_item(OP_PUSH, rand_pixel(), 1'b1);
    for (int r = 0; r < reps * w; r++) begin
      if (noisy && $urandom_range(0, 11) == 0) queue_item(OP_PUSH, rand_pixel(), 1'b1);
      queue_item(OP_REPLAY, rand_pixel(), 1'b1);
    end
    if (noisy && $urandom_range(0, 5) == 0) queue_item(OP_REPLAY, rand_pixel(), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned s_val;
    int unsigned w_val;
    int unsigned rows;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values (scale 1, width 1): each push is a full row, extreme pixels,
    // and a replay with nothing pending.
    queue_item(OP_PUSH, 24'h000000, 1'b1);
    queue_item(OP_PUSH, 24'hFFFFFF, 1'b1);
    queue_item(OP_REPLAY, 24'hA5A5A5, 1'b0);
    drain();

    // Scale 0 acts as 1; width above the maximum saturates. Partial row, then
    // the exact maximum, then a width that shrinks under the write column so
    // the next push closes the row.
    write_reg(REG_SCALE, 32'd0);
    write_reg(REG_ROW_WIDTH, 32'd4095);
    queue_item(OP_PUSH, 24'h123456, 1'b1);
    queue_item(OP_PUSH, 24'hFEDCBA, 1'b1);
    drain();
    write_reg(REG_ROW_WIDTH, 32'd2048);
    queue_item(OP_PUSH, 24'h0F0F0F, 1'b1);
    drain();
    write_reg(REG_ROW_WIDTH, 32'd2);
    queue_item(OP_PUSH, 24'hF0F0F0, 1'b1);
    drain();

    // Two-pixel row at scale 3, a push refused during replay, then the scale
    // drops mid-replay: the two pending rows stay, copies follow the new scale.
    write_reg(REG_SCALE, 32'd3);
    queue_item(OP_PUSH, 24'h112233, 1'b1);
    queue_item(OP_PUSH, 24'h445566, 1'b1);
    queue_item(OP_PUSH, 24'h778899, 1'b1);
    queue_item(OP_REPLAY, 24'h000000, 1'b1);
    drain();
    write_reg(REG_SCALE, 32'd2);
    repeat (3) queue_item(OP_REPLAY, 24'hFFFFFF, 1'b1);
    queue_item(OP_REPLAY, 24'h000000, 1'b0);
    drain();

    // Random phases: fresh registers each time, a few rows of random content.
    phase = 0;
    while (n_real < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       s_val = 0;
        1:       s_val = 1;
        2:       s_val = MAX_SCALE;
        3:       s_val = $urandom_range(MAX_SCALE + 1, 31);
        default: s_val = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 7))
        0:       w_val = 0;
        1:       w_val = 1;
        2:       w_val = $urandom_range(6, 24);
        default: w_val = $urandom_range(2, 5);
      endcase
      // Wide rows stay at low scale to keep the run short.
      if (w_val > 5) s_val = $urandom_range(1, 3);
      rows = (w_val > 5) ? 1 : $urandom_range(1, 3);
      calm = ($urandom_range(0, 3) == 0);

      // Second phase: long receiver hold-off while the sender streams a
      // scale-16 row, so the queue fills and in_stall must rise.
      if (phase == 1) begin
        s_val = MAX_SCALE;
        w_val = 2;
        rows = 1;
        calm = 1'b1;
        hold_reqs = hold_reqs + 1;
      end

      write_reg(REG_SCALE, s_val);
      write_reg(REG_ROW_WIDTH, w_val);
      for (int r = 0; r < rows; r++) send_row(phase != 1);
      drain();
      phase++;
    end

    if (mismatches == 0) begin
      $display("pixel_replication_upscaler_unit test passed");
    end else begin
      $display("pixel_replication_upscaler_unit test failed");
    end
    $finish;
  end

endmodule
